// ----- rtl/b64se_pkg.sv -----
// Shared types, constants and character functions for the base64 stream encoder.
package b64se_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    // One group of three bytes waiting to be encoded into four characters.
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n_pad;
        logic       last;
    } t_group;

    // Six-bit value of character position idx within a group.
    function automatic logic [5:0] group_sextet(t_group g, logic [1:0] idx);
        logic [5:0] s;
        case (idx)
            2'd0:    s = g.b0[7:2];
            2'd1:    s = {g.b0[1:0], g.b1[7:4]};
            2'd2:    s = {g.b1[3:0], g.b2[7:6]};
            2'd3:    s = g.b2[5:0];
            default: s = 6'd0;
        endcase
        return s;
    endfunction

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_char(logic [5:0] v);
        logic [7:0] c;
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            c = 8'h41 + w;
        end else if (v < 6'd52) begin
            c = 8'h47 + w;
        end else if (v < 6'd62) begin
            c = w - 8'd4;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ----- rtl/b64se_front.sv -----
// Front end: accepts bytes, gathers them into groups of three and hands groups to the queue.
module b64se_front
    import b64se_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_stall,
    input  logic     i_full,
    output logic     o_push,
    output t_group   o_grp
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [7:0] r_pend0;
    logic [7:0] r_pend1;
    logic [1:0] pos_eff;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    // Position three never arises; it is read as an empty group.
    assign pos_eff = (r_pos == 2'd3) ? 2'd0 : r_pos;

    always_comb begin
        n_pos  = r_pos;
        o_push = 1'b0;
        o_grp  = '0;
        if (accept) begin
            case (pos_eff)
                2'd0: begin
                    o_grp = '{b0: i_item.data_byte, b1: 8'd0, b2: 8'd0,
                              n_pad: 2'd2, last: 1'b1};
                    o_push = i_item.last_byte;
                    n_pos  = i_item.last_byte ? 2'd0 : 2'd1;
                end
                2'd1: begin
                    o_grp = '{b0: r_pend0, b1: i_item.data_byte, b2: 8'd0,
                              n_pad: 2'd1, last: 1'b1};
                    o_push = i_item.last_byte;
                    n_pos  = i_item.last_byte ? 2'd0 : 2'd2;
                end
                default: begin
                    o_grp = '{b0: r_pend0, b1: r_pend1, b2: i_item.data_byte,
                              n_pad: 2'd0, last: i_item.last_byte};
                    o_push = 1'b1;
                    n_pos  = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && pos_eff == 2'd0) begin
            r_pend0 <= i_item.data_byte;
        end
        if (accept && pos_eff == 2'd1) begin
            r_pend1 <= i_item.data_byte;
        end
    end

endmodule

// ----- rtl/b64se_queue.sv -----
// Two-entry queue of byte groups between the front and back ends.
module b64se_queue
    import b64se_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_grp,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_group o_grp
);

    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

    t_group            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [PtrW:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (PtrW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_grp   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

endmodule

// ----- rtl/b64se_back.sv -----
// Back end: four characters per queued group, one per cycle unless stalled, via an output register.
module b64se_back
    import b64se_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_grp_valid,
    input  t_group    i_grp,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic      r_busy;
    logic      n_busy;
    t_group    r_grp;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      load;
    logic [5:0] sextet;
    logic      is_pad;

    assign load   = r_busy && (!r_out_valid || !i_stall);
    assign o_pop  = !r_busy || (load && r_idx == 2'd3);
    assign sextet = group_sextet(r_grp, r_idx);
    // Padding fills the last n_pad positions of the group.
    assign is_pad = ({1'b0, r_idx} >= (3'd4 - {1'b0, r_grp.n_pad}));

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (load) begin
            n_out_valid     = 1'b1;
            n_out.out_char  = is_pad ? PAD_CHAR : b64_char(sextet);
            n_out.last_char = (r_idx == 2'd3) && r_grp.last;
            n_idx           = r_idx + 2'd1;
            if (r_idx == 2'd3) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop && i_grp_valid) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_pop && i_grp_valid) begin
            r_grp <= i_grp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    a_no_pad_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && (r_idx == 2'd0 || r_idx == 2'd1) |=> r_out.out_char != PAD_CHAR)
        else $error("pad character in one of the first two positions");
    a_last_on_fourth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_idx != 2'd3 |=> !r_out.last_char)
        else $error("last_char set before the fourth character of a group");
    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_idx != 2'd3 |=> r_busy)
        else $error("group dropped before all four characters were sent");
`endif

endmodule

// ----- rtl/base64_stream_encoder.sv -----
// Top level of the streaming base64 encoder.
// The encoder takes one raw byte per item and sends standard base64 characters (A-Z, a-z,
// 0-9, '+', '/', with '=' padding), one character per item on the output channel; the
// character that ends a message carries last_char. Bytes are accepted one per cycle while
// the two-entry group queue has room. Every third byte, or a byte flagged as last, closes a
// group, which the back end spells out as four characters, with '=' padding for a short
// final group. The output channel, at one character per cycle while the receiver does not
// stall, sets the sustained rate. A result passes through the queue, the back end's group
// register and the output register before it appears on the output. The output register
// holds a character steady while the receiver stalls, and the back end pauses until that
// character is taken; the queue lets the front end keep taking bytes while the back end is
// paused, until two closed groups are waiting.
module base64_stream_encoder
    import b64se_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_in_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_out_item,
    input  logic      i_stall
);

    // Group handoff between front end and queue.
    logic   push;
    t_group push_grp;
    logic   queue_full;

    // Group handoff between queue and back end.
    logic   pop;
    logic   grp_valid;
    t_group head_grp;

    b64se_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_in_item),
        .o_stall (o_stall),
        .i_full  (queue_full),
        .o_push  (push),
        .o_grp   (push_grp)
    );

    b64se_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (push_grp),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (grp_valid),
        .o_grp   (head_grp)
    );

    b64se_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp_valid (grp_valid),
        .i_grp       (head_grp),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_item      (o_out_item),
        .i_stall     (i_stall)
    );

endmodule
